### hw/rtl/mpbsa_pkg.sv
// ----------------------------------------------------------------------------
// Seat allocator package
// Shared constants, defaults and codes of the multi-pool bitmap allocator.
// ----------------------------------------------------------------------------
package mpbsa_pkg;

    // Number of slot classes kept for every inventory.
    localparam int NUM_CLASSES = 6;

    // Bits in one bitmap word of the state memory.
    localparam int WORD_BITS = 64;

    // Default sizing of the block.
    localparam int MAX_SLOTS_DEF       = 1024;
    localparam int NUM_INVENTORIES_DEF = 8;
    localparam int MAX_RESERVE_DEF     = 16;

    // Field widths of the ports.
    localparam int CMD_W   = 2;
    localparam int INV_W   = 3;
    localparam int CLS_W   = 3;
    localparam int RCNT_W  = 5;
    localparam int SLOT_W  = 11;
    localparam int STAT_W  = 2;
    localparam int CFGI_W  = 3;

    // Request codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY   = 2'd0,
        CMD_RESERVE = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_MARK    = 2'd3
    } cmd_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 2'd0,
        ST_SHORT   = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

endpackage

### hw/rtl/mpbsa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mpbsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/multi_pool_bitmap_seat_allocator_unit.sv
// ----------------------------------------------------------------------------
// Multi-pool bitmap seat allocator
// Keeps taken/free bitmaps of six slot classes per inventory in one RAM and
// serves query, reserve, release and mark requests.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap RAM to all free, one word a cycle,
// over all NUM_INVENTORIES*6*ceil(MAX_SLOTS/64) words (768 by default) with
// busy high. A request is taken when start is high and busy low; every word of
// a result is shown for one cycle with done high and cannot be held off. The
// time per request, counted from one accepted request to the earliest next
// one, is set by the single RAM read port (W = ceil(MAX_SLOTS/64) words per
// class): a query reads all W words of all six classes, a reserve reads W for
// its free count, then scans words and grants slots, release and mark rewrite
// one word, and a rejected or zero-count request reads none. Class sizes must
// be written only while the block is idle; the block does not enforce this.
module multi_pool_bitmap_seat_allocator_unit #(
    parameter int MAX_SLOTS       = mpbsa_pkg::MAX_SLOTS_DEF,
    parameter int NUM_INVENTORIES = mpbsa_pkg::NUM_INVENTORIES_DEF,
    parameter int MAX_RESERVE     = mpbsa_pkg::MAX_RESERVE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration port
    input  logic                          cfg_we,
    input  logic [mpbsa_pkg::CFGI_W-1:0]  cfg_index,
    input  logic [mpbsa_pkg::SLOT_W-1:0]  cfg_data,
    // Request side
    input  logic                          start,
    output logic                          busy,
    input  logic [mpbsa_pkg::CMD_W-1:0]   command,
    input  logic [mpbsa_pkg::INV_W-1:0]   inventory_slot,
    input  logic [mpbsa_pkg::CLS_W-1:0]   slot_class,
    input  logic [mpbsa_pkg::RCNT_W-1:0]  request_count,
    input  logic [mpbsa_pkg::SLOT_W-1:0]  slot_number,
    // Result side
    output logic                          done,
    output logic [mpbsa_pkg::STAT_W-1:0]  status,
    output logic [mpbsa_pkg::SLOT_W-1:0]  granted_slot,
    output logic                          last_result,
    output logic [mpbsa_pkg::SLOT_W-1:0]  free_class0,
    output logic [mpbsa_pkg::SLOT_W-1:0]  free_class1,
    output logic [mpbsa_pkg::SLOT_W-1:0]  free_class2,
    output logic [mpbsa_pkg::SLOT_W-1:0]  free_class3,
    output logic [mpbsa_pkg::SLOT_W-1:0]  free_class4,
    output logic [mpbsa_pkg::SLOT_W-1:0]  free_class5
);

    localparam int NC    = mpbsa_pkg::NUM_CLASSES;
    localparam int WB    = mpbsa_pkg::WORD_BITS;
    localparam int WPC   = (MAX_SLOTS + WB - 1) / WB;
    localparam int DEPTH = NUM_INVENTORIES * NC * WPC;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = (WPC > 1) ? $clog2(WPC) : 1;
    localparam int CW    = $clog2(MAX_SLOTS + 1);
    localparam int SW    = (CW > mpbsa_pkg::SLOT_W) ? CW : mpbsa_pkg::SLOT_W;
    localparam int BW    = $clog2(WB);
    localparam int PCW   = BW + 1;
    localparam int CLW   = mpbsa_pkg::CLS_W;
    localparam int RW    = mpbsa_pkg::RCNT_W;
    localparam int OW    = mpbsa_pkg::SLOT_W;
    localparam int INV_W_L = mpbsa_pkg::INV_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_Q_RD,
        S_Q_ACC,
        S_R_CRD,
        S_R_CACC,
        S_R_TRD,
        S_R_TLD,
        S_R_TAKE,
        S_M_RD,
        S_M_WR
    } state_t;

    state_t                state_reg;
    logic [OW-1:0]         size_reg [NC];
    logic [AW-1:0]         clr_reg;
    mpbsa_pkg::cmd_t       cmd_reg;
    logic [INV_W_L-1:0]    inv_reg;
    logic [CLW-1:0]        cls_reg;
    logic [RW-1:0]         rem_reg;
    logic [WW-1:0]         w_reg;
    logic [BW-1:0]         bit_reg;
    logic [CW-1:0]         acc_reg;
    logic [WB-1:0]         word_reg;

    logic                  done_reg;
    mpbsa_pkg::status_t    status_reg;
    logic [OW-1:0]         granted_reg;
    logic                  last_reg;
    logic [OW-1:0]         free_reg [NC];

    // Memory port signals.
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WB-1:0]         mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [WB-1:0]         mem_rdata;
    logic [AW-1:0]         item_addr;

    // Word processing signals.
    logic [SW-1:0]         cur_size;
    logic [WB-1:0]         cur_mask;
    logic [WB-1:0]         rd_free;
    logic [PCW-1:0]        rd_pop;
    logic [CW-1:0]         acc_sum;
    logic [WB-1:0]         take_free;
    logic                  take_found;
    logic [BW-1:0]         take_idx;
    logic [WB-1:0]         take_bit;
    logic                  last_word;

    // Effective size of a class: absent for an illegal class, clipped to MAX_SLOTS.
    function automatic logic [SW-1:0] eff_size(input logic [CLW-1:0] c,
                                               input logic [OW-1:0] sizes [NC]);
        logic [SW-1:0] s;
        s = '0;
        if (32'(c) < NC)
        begin
            s = SW'(sizes[c]);
        end
        if (32'(s) > MAX_SLOTS)
        begin
            s = SW'(MAX_SLOTS);
        end
        return s;
    endfunction

    // Bits of word w that lie below the class size.
    function automatic logic [WB-1:0] word_mask(input logic [SW-1:0] s,
                                                input logic [WW-1:0] w);
        int lo;
        int n;
        logic [WB-1:0] m;
        lo = 32'(w) * WB;
        n  = 32'(s) - lo;
        if (n >= WB)
        begin
            m = '1;
        end
        else if (n <= 0)
        begin
            m = '0;
        end
        else
        begin
            m = {WB{1'b1}} >> (WB - n);
        end
        return m;
    endfunction

    // Address of the current bitmap word.
    assign item_addr = AW'((32'(inv_reg) * NC + 32'(cls_reg)) * WPC + 32'(w_reg));
    assign mem_raddr = item_addr;

    // Free bits of the word just read and of the word under allocation.
    always_comb
    begin
        cur_size  = eff_size(cls_reg, size_reg);
        cur_mask  = word_mask(cur_size, w_reg);
        rd_free   = ~mem_rdata & cur_mask;
        rd_pop    = '0;
        for (int i = 0; i < WB; i++)
        begin
            rd_pop = rd_pop + PCW'(rd_free[i]);
        end
        acc_sum   = acc_reg + CW'(rd_pop);
        last_word = (32'(w_reg) == WPC - 1);

        take_free  = ~word_reg & cur_mask;
        take_found = |take_free;
        take_idx   = '0;
        for (int i = WB - 1; i >= 0; i--)
        begin
            if (take_free[i])
            begin
                take_idx = BW'(i);
            end
        end
        take_bit = take_found ? (WB'(1) << take_idx) : '0;
    end

    // Memory write selection: clearing sweep, reserve write-back, single-bit update.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = item_addr;
        mem_wdata = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
            end
            S_R_TAKE:
            begin
                mem_we    = !take_found || (rem_reg == RW'(1));
                mem_wdata = word_reg | take_bit;
            end
            S_M_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                mem_wdata[bit_reg] = (cmd_reg == mpbsa_pkg::CMD_MARK);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    mpbsa_ram #(
        .WIDTH (WB),
        .DEPTH (DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NC; i++)
            begin
                size_reg[i] <= '0;
            end
        end
        else if (cfg_we && (32'(cfg_index) < NC))
        begin
            size_reg[cfg_index] <= cfg_data;
        end
    end

    // Request sequencer with registered result word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            done_reg    <= 1'b0;
            cmd_reg     <= mpbsa_pkg::CMD_QUERY;
            inv_reg     <= '0;
            cls_reg     <= '0;
            rem_reg     <= '0;
            w_reg       <= '0;
            bit_reg     <= '0;
            acc_reg     <= '0;
            word_reg    <= '0;
            status_reg  <= mpbsa_pkg::ST_DONE;
            granted_reg <= '0;
            last_reg    <= 1'b0;
            for (int i = 0; i < NC; i++)
            begin
                free_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (32'(clr_reg) == DEPTH - 1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg     <= mpbsa_pkg::cmd_t'(command);
                        inv_reg     <= inventory_slot;
                        cls_reg     <= slot_class;
                        rem_reg     <= request_count;
                        w_reg       <= WW'(32'(slot_number - OW'(1)) / WB);
                        bit_reg     <= BW'(slot_number - OW'(1));
                        acc_reg     <= '0;
                        granted_reg <= '0;
                        last_reg    <= 1'b1;
                        status_reg  <= mpbsa_pkg::ST_DONE;
                        for (int i = 0; i < NC; i++)
                        begin
                            free_reg[i] <= '0;
                        end
                        if (32'(inventory_slot) >= NUM_INVENTORIES)
                        begin
                            status_reg <= mpbsa_pkg::ST_IGNORED;
                            done_reg   <= 1'b1;
                        end
                        else if (mpbsa_pkg::cmd_t'(command) == mpbsa_pkg::CMD_QUERY)
                        begin
                            cls_reg   <= '0;
                            w_reg     <= '0;
                            state_reg <= S_Q_RD;
                        end
                        else if (32'(slot_class) >= NC)
                        begin
                            status_reg <= mpbsa_pkg::ST_IGNORED;
                            done_reg   <= 1'b1;
                        end
                        else if (mpbsa_pkg::cmd_t'(command) == mpbsa_pkg::CMD_RESERVE)
                        begin
                            w_reg <= '0;
                            if (32'(request_count) > MAX_RESERVE)
                            begin
                                status_reg <= mpbsa_pkg::ST_IGNORED;
                                done_reg   <= 1'b1;
                            end
                            else if (request_count == '0)
                            begin
                                done_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_R_CRD;
                            end
                        end
                        else if ((slot_number == '0) ||
                                 (SW'(slot_number) > eff_size(slot_class, size_reg)))
                        begin
                            status_reg <= mpbsa_pkg::ST_IGNORED;
                            done_reg   <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_M_RD;
                        end
                    end
                end

                // Query: count free bits word by word, class by class.
                S_Q_RD:
                begin
                    state_reg <= S_Q_ACC;
                end

                S_Q_ACC:
                begin
                    if (last_word)
                    begin
                        free_reg[cls_reg] <= OW'(acc_sum);
                        acc_reg <= '0;
                        w_reg   <= '0;
                        if (32'(cls_reg) == NC - 1)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            cls_reg   <= cls_reg + CLW'(1);
                            state_reg <= S_Q_RD;
                        end
                    end
                    else
                    begin
                        acc_reg   <= acc_sum;
                        w_reg     <= w_reg + WW'(1);
                        state_reg <= S_Q_RD;
                    end
                end

                // Reserve, first pass: enough free slots?
                S_R_CRD:
                begin
                    state_reg <= S_R_CACC;
                end

                S_R_CACC:
                begin
                    if (last_word)
                    begin
                        w_reg <= '0;
                        if (acc_sum < CW'(rem_reg))
                        begin
                            status_reg <= mpbsa_pkg::ST_SHORT;
                            done_reg   <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_R_TRD;
                        end
                    end
                    else
                    begin
                        acc_reg   <= acc_sum;
                        w_reg     <= w_reg + WW'(1);
                        state_reg <= S_R_CRD;
                    end
                end

                // Reserve, second pass: grant the lowest free slots one a cycle within a word.
                S_R_TRD:
                begin
                    state_reg <= S_R_TLD;
                end

                S_R_TLD:
                begin
                    word_reg  <= mem_rdata;
                    state_reg <= S_R_TAKE;
                end

                S_R_TAKE:
                begin
                    if (take_found)
                    begin
                        word_reg    <= word_reg | take_bit;
                        rem_reg     <= rem_reg - RW'(1);
                        done_reg    <= 1'b1;
                        status_reg  <= mpbsa_pkg::ST_DONE;
                        granted_reg <= OW'(32'(w_reg) * WB + 32'(take_idx) + 1);
                        last_reg    <= (rem_reg == RW'(1));
                        if (rem_reg == RW'(1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        w_reg     <= w_reg + WW'(1);
                        state_reg <= S_R_TRD;
                    end
                end

                // Release or mark: read, change one bit, write back.
                S_M_RD:
                begin
                    state_reg <= S_M_WR;
                end

                S_M_WR:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Port drive.
    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign granted_slot = granted_reg;
    assign last_result  = last_reg;
    assign free_class0  = free_reg[0];
    assign free_class1  = free_reg[1];
    assign free_class2  = free_reg[2];
    assign free_class3  = free_reg[3];
    assign free_class4  = free_reg[4];
    assign free_class5  = free_reg[5];

    // The bitmap RAM is never written while the block waits for a request.
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("bitmap write while idle");

    // Allocation runs only while grants are still owed.
    a_take_owed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_R_TAKE) |-> (rem_reg != '0))
        else $error("allocation with no grant owed");

    // A granted slot number comes only with a done status.
    a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (granted_reg != '0)) |-> (status_reg == mpbsa_pkg::ST_DONE))
        else $error("slot granted with failing status");

    // An accepted request either answers at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done_reg))
        else $error("accepted request dropped");

endmodule

### tb/multi_pool_bitmap_seat_allocator_unit_test.sv
// ----------------------------------------------------------------------------
// Seat allocator unit test
// Drives query, reserve, release and mark requests into the allocator under
// several class size settings. A directed table comes first, then random
// traffic. Result words are checked against a local bitmap model or a typed row.
// ----------------------------------------------------------------------------
module multi_pool_bitmap_seat_allocator_unit_test;

    localparam int SLOTS = mpbsa_pkg::MAX_SLOTS_DEF;
    localparam int INVS  = mpbsa_pkg::NUM_INVENTORIES_DEF;
    localparam int RMAX  = mpbsa_pkg::MAX_RESERVE_DEF;
    localparam int NCL   = mpbsa_pkg::NUM_CLASSES;
    localparam int CMDW  = mpbsa_pkg::CMD_W;
    localparam int IW    = mpbsa_pkg::INV_W;
    localparam int CLW   = mpbsa_pkg::CLS_W;
    localparam int RCW   = mpbsa_pkg::RCNT_W;
    localparam int SLW   = mpbsa_pkg::SLOT_W;
    localparam int STW   = mpbsa_pkg::STAT_W;
    localparam int CFW   = mpbsa_pkg::CFGI_W;

    // Short names for the request and status codes.
    localparam mpbsa_pkg::cmd_t    C_QRY  = mpbsa_pkg::CMD_QUERY;
    localparam mpbsa_pkg::cmd_t    C_RSV  = mpbsa_pkg::CMD_RESERVE;
    localparam mpbsa_pkg::cmd_t    C_REL  = mpbsa_pkg::CMD_RELEASE;
    localparam mpbsa_pkg::cmd_t    C_MRK  = mpbsa_pkg::CMD_MARK;
    localparam mpbsa_pkg::status_t S_DONE = mpbsa_pkg::ST_DONE;
    localparam mpbsa_pkg::status_t S_SHRT = mpbsa_pkg::ST_SHORT;
    localparam mpbsa_pkg::status_t S_IGN  = mpbsa_pkg::ST_IGNORED;

    // One result word as the block shows it.
    typedef struct {
        mpbsa_pkg::status_t    status;
        logic [SLW-1:0]        granted;
        logic                  last;
        logic [5:0][SLW-1:0]   free;
    } seat_word_t;

    // One row of the directed table; typed rows carry a fixed expectation.
    typedef struct {
        mpbsa_pkg::cmd_t    cmd;
        logic [IW-1:0]      inv;
        logic [CLW-1:0]     cls;
        logic [RCW-1:0]     cnt;
        logic [SLW-1:0]     num;
        bit                 typed;
        mpbsa_pkg::status_t st;
    } seat_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFW-1:0] cfg_index = '0;
    logic [SLW-1:0] cfg_data = '0;
    logic start = 1'b0;
    logic busy;
    logic [CMDW-1:0] command = '0;
    logic [IW-1:0] inventory_slot = '0;
    logic [CLW-1:0] slot_class = '0;
    logic [RCW-1:0] request_count = '0;
    logic [SLW-1:0] slot_number = '0;
    logic done;
    logic [STW-1:0] status;
    logic [SLW-1:0] granted_slot;
    logic last_result;
    logic [SLW-1:0] free_class0, free_class1, free_class2;
    logic [SLW-1:0] free_class3, free_class4, free_class5;

    // Local copy of the bitmaps and sizes.
    logic [SLOTS-1:0] taken_map [INVS][NCL];
    logic [SLW-1:0] size_reg [NCL];

    seat_word_t pending_words[$];
    seat_row_t  rows[$];
    int mismatches = 0;
    int words_seen = 0;
    int items_sent = 0;
    int grants_seen = 0;

    multi_pool_bitmap_seat_allocator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .command(command), .inventory_slot(inventory_slot), .slot_class(slot_class),
        .request_count(request_count), .slot_number(slot_number),
        .done(done), .status(status), .granted_slot(granted_slot),
        .last_result(last_result),
        .free_class0(free_class0), .free_class1(free_class1),
        .free_class2(free_class2), .free_class3(free_class3),
        .free_class4(free_class4), .free_class5(free_class5)
    );

    always #4 clk = ~clk;

    // Safety net against a hung block.
    initial
    begin
        #(8 * 900000);
        $display("timeout: %0d words still expected", pending_words.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int clamp_size(int cls);
        return (size_reg[cls] > SLOTS) ? SLOTS : int'(size_reg[cls]);
    endfunction

    function automatic int count_free(int inv, int cls);
        int n;
        n = 0;
        for (int p = 0; p < clamp_size(cls); p++)
            if (!taken_map[inv][cls][p])
                n++;
        return n;
    endfunction

    function automatic seat_word_t make_word(mpbsa_pkg::status_t st, int slot, bit last);
        seat_word_t w;
        w.status = st;
        w.granted = slot[SLW-1:0];
        w.last = last;
        w.free = '0;
        return w;
    endfunction

    function automatic seat_row_t make_row(mpbsa_pkg::cmd_t cmd, logic [IW-1:0] inv,
                                           logic [CLW-1:0] cls, logic [RCW-1:0] cnt,
                                           logic [SLW-1:0] num, bit typed,
                                           mpbsa_pkg::status_t st);
        seat_row_t r;
        r.cmd = cmd;
        r.inv = inv;
        r.cls = cls;
        r.cnt = cnt;
        r.num = num;
        r.typed = typed;
        r.st = st;
        return r;
    endfunction

    // Applies one request to the local bitmaps and returns its result words.
    task automatic allocate_seats(input mpbsa_pkg::cmd_t cmd, input int inv, input int cls,
                                  input int cnt, input int num,
                                  output seat_word_t words[$]);
        seat_word_t w;
        int k;
        words = {};
        if (inv >= INVS)
            words = {words, make_word(S_IGN, 0, 1'b1)};
        else if (cmd == C_QRY)
        begin
            w = make_word(S_DONE, 0, 1'b1);
            for (int c = 0; c < NCL; c++)
                w.free[c] = SLW'(count_free(inv, c));
            words = {words, w};
        end
        else if (cls >= NCL)
            words = {words, make_word(S_IGN, 0, 1'b1)};
        else if (cmd == C_RSV)
        begin
            if (cnt > RMAX)
                words = {words, make_word(S_IGN, 0, 1'b1)};
            else if (cnt == 0)
                words = {words, make_word(S_DONE, 0, 1'b1)};
            else if (count_free(inv, cls) < cnt)
                words = {words, make_word(S_SHRT, 0, 1'b1)};
            else
            begin
                k = 0;
                for (int p = 0; p < clamp_size(cls) && k < cnt; p++)
                    if (!taken_map[inv][cls][p])
                    begin
                        taken_map[inv][cls][p] = 1'b1;
                        k++;
                        words = {words, make_word(S_DONE, p + 1, k == cnt)};
                    end
            end
        end
        else if (num == 0 || num > clamp_size(cls))
            words = {words, make_word(S_IGN, 0, 1'b1)};
        else
        begin
            taken_map[inv][cls][num-1] = (cmd == C_MRK);
            words = {words, make_word(S_DONE, 0, 1'b1)};
        end
    endtask

    // Sends one request word, waits for acceptance, then drops start and idles for a nonzero gap.
    task automatic send_request(input seat_row_t r, input int gap);
        seat_word_t words[$];
        command <= r.cmd;
        inventory_slot <= r.inv;
        slot_class <= r.cls;
        request_count <= r.cnt;
        slot_number <= r.num;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        allocate_seats(r.cmd, int'(r.inv), int'(r.cls), int'(r.cnt), int'(r.num), words);
        if (r.typed)
            words = {make_word(r.st, 0, 1'b1)};
        pending_words = {pending_words, words};
        items_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds off until every result is in and the block is idle.
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all six class sizes, one per cycle, while idle.
    task automatic write_sizes(input int s0, input int s1, input int s2,
                               input int s3, input int s4, input int s5);
        int vals[6];
        vals = '{s0, s1, s2, s3, s4, s5};
        for (int i = 0; i < NCL; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= i[CFW-1:0];
            cfg_data <= vals[i][SLW-1:0];
            size_reg[i] = vals[i][SLW-1:0];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 250);
    endfunction

    function automatic int pick_size();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1024;
            2: return 64;
            3: return 65;
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    // Builds a random request; most are well formed.
    function automatic seat_row_t random_request();
        seat_row_t r;
        int sel;
        int lim;
        r.typed = 1'b0;
        r.st = S_DONE;
        r.inv = IW'($urandom_range(0, 7));
        r.cmd = mpbsa_pkg::cmd_t'($urandom_range(0, 3));
        r.cls = ($urandom_range(0, 19) == 0) ? CLW'($urandom_range(6, 7))
                                             : CLW'($urandom_range(0, 5));
        sel = $urandom_range(0, 19);
        r.cnt = (sel == 0) ? RCW'($urandom_range(17, 31))
              : (sel == 1) ? RCW'(0) : RCW'($urandom_range(1, 16));
        sel = $urandom_range(0, 19);
        lim = clamp_size(int'(r.cls) % 6);
        if (sel == 0)
            r.num = SLW'($urandom_range(0, 2047));
        else if (sel == 1)
            r.num = '0;
        else
            r.num = SLW'($urandom_range(1, (lim > 0) ? lim : 1));
        return r;
    endfunction

    // Result checker: every done word against the oldest expectation.
    always @(posedge clk)
    begin
        seat_word_t e;
        logic [5:0][SLW-1:0] got_free;
        if (rst_n && done)
        begin
            words_seen++;
            got_free = {free_class5, free_class4, free_class3,
                        free_class2, free_class1, free_class0};
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: status %0d slot %0d", status, granted_slot);
            end
            else
            begin
                e = pending_words.pop_front();
                if (status == S_DONE && granted_slot != 0)
                    grants_seen++;
                if (status !== e.status || granted_slot !== e.granted ||
                    last_result !== e.last || got_free !== e.free)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st %0d slot %0d last %0d free %h, ",
                                  "got st %0d slot %0d last %0d free %h"},
                                 e.status, e.granted, e.last, e.free,
                                 status, granted_slot, last_result, got_free);
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < INVS; i++)
            for (int c = 0; c < NCL; c++)
                taken_map[i][c] = '0;
        for (int c = 0; c < NCL; c++)
            size_reg[c] = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // Let the clearing sweep finish before the first request.
        @(posedge clk);
        while (busy)
            @(posedge clk);

        // With all sizes at reset every class is absent.
        send_request(make_row(C_QRY, 3'd2, 3'd0, 5'd0, 11'd0, 1'b0, S_DONE), 1);
        send_request(make_row(C_RSV, 3'd0, 3'd0, 5'd1, 11'd0, 1'b1, S_SHRT), 0);
        drain();
        write_sizes(1024, 1, 0, 64, 65, 3);

        // Directed table: extremes, all commands, and the corner cases.
        rows = {rows, make_row(C_QRY, 3'd0, 3'd0, 5'd0,  11'd0,    1'b0, S_DONE)};
        rows = {rows, make_row(C_RSV, 3'd0, 3'd6, 5'd1,  11'd0,    1'b1, S_IGN)};
        rows = {rows, make_row(C_MRK, 3'd0, 3'd7, 5'd0,  11'd1,    1'b1, S_IGN)};
        rows = {rows, make_row(C_RSV, 3'd0, 3'd0, 5'd17, 11'd0,    1'b1, S_IGN)};
        rows = {rows, make_row(C_RSV, 3'd0, 3'd0, 5'd31, 11'd0,    1'b1, S_IGN)};
        rows = {rows, make_row(C_RSV, 3'd0, 3'd0, 5'd0,  11'd0,    1'b1, S_DONE)};
        rows = {rows, make_row(C_RSV, 3'd0, 3'd2, 5'd1,  11'd0,    1'b1, S_SHRT)};
        rows = {rows, make_row(C_REL, 3'd0, 3'd0, 5'd0,  11'd0,    1'b1, S_IGN)};
        rows = {rows, make_row(C_MRK, 3'd0, 3'd0, 5'd0,  11'd1025, 1'b1, S_IGN)};
        rows = {rows, make_row(C_MRK, 3'd0, 3'd0, 5'd0,  11'd2047, 1'b1, S_IGN)};
        rows = {rows, make_row(C_REL, 3'd0, 3'd1, 5'd0,  11'd2,    1'b1, S_IGN)};
        rows = {rows, make_row(C_RSV, 3'd0, 3'd1, 5'd1,  11'd0,    1'b0, S_DONE)};
        rows = {rows, make_row(C_RSV, 3'd0, 3'd1, 5'd1,  11'd0,    1'b1, S_SHRT)};
        rows = {rows, make_row(C_REL, 3'd0, 3'd1, 5'd1,  11'd1,    1'b1, S_DONE)};
        rows = {rows, make_row(C_REL, 3'd0, 3'd1, 5'd1,  11'd1,    1'b1, S_DONE)};
        rows = {rows, make_row(C_MRK, 3'd1, 3'd5, 5'd0,  11'd2,    1'b1, S_DONE)};
        rows = {rows, make_row(C_MRK, 3'd1, 3'd5, 5'd0,  11'd2,    1'b1, S_DONE)};
        rows = {rows, make_row(C_RSV, 3'd1, 3'd5, 5'd2,  11'd0,    1'b0, S_DONE)};
        rows = {rows, make_row(C_MRK, 3'd7, 3'd0, 5'd0,  11'd1024, 1'b1, S_DONE)};
        rows = {rows, make_row(C_RSV, 3'd7, 3'd0, 5'd16, 11'd0,    1'b0, S_DONE)};
        rows = {rows, make_row(C_MRK, 3'd7, 3'd3, 5'd0,  11'd64,   1'b0, S_DONE)};
        rows = {rows, make_row(C_RSV, 3'd7, 3'd4, 5'd16, 11'd0,    1'b0, S_DONE)};
        rows = {rows, make_row(C_QRY, 3'd7, 3'd7, 5'd31, 11'd2047, 1'b0, S_DONE)};
        foreach (rows[i])
            send_request(rows[i], pick_gap() % 5);
        drain();

        // Shrinking and regrowing a size keeps the bits above it.
        write_sizes(1024, 1, 0, 10, 65, 3);
        send_request(make_row(C_QRY, 3'd7, 3'd0, 5'd0, 11'd0, 1'b0, S_DONE), 0);
        drain();
        write_sizes(1024, 1, 0, 64, 65, 3);
        send_request(make_row(C_QRY, 3'd7, 3'd0, 5'd0, 11'd0, 1'b0, S_DONE), 0);
        drain();

        // Random phases, each under its own sizes; the last one at full size.
        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph == 3)
                write_sizes(1024, 1024, 1024, 1024, 1024, 1024);
            else
                write_sizes(pick_size(), pick_size(), pick_size(),
                            pick_size(), pick_size(), pick_size());
            for (int n = 0; n < 50; n++)
                send_request(random_request(), pick_gap());
            drain();
        end

        repeat (250) @(posedge clk);
        $display("Sent %0d requests under several class size settings.", items_sent);
        $display("Checked %0d result words, %0d of them granted slots.",
                 words_seen, grants_seen);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches, %0d words missing", mismatches, pending_words.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/mpbsa_pkg.sv
hw/rtl/mpbsa_ram.sv
hw/rtl/multi_pool_bitmap_seat_allocator_unit.sv
tb/multi_pool_bitmap_seat_allocator_unit_test.sv
